@@ rtl/core/stable_priority_queue_unit_macros.svh @@
// Assertion macros shared by the priority queue checker.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

@@ rtl/core/spq_pkg.sv @@
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;
  localparam int unsigned TAG_BITS_DEF  = 32;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ rtl/core/spq_mem.sv @@
// Entry store: one write port, one read port, registered read data.
module spq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/spq_ctrl.sv @@
// Sequencer: sorted insert by backward shift, pop/peek at head, result register.
module spq_ctrl #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 8,
  parameter int unsigned TAG_BITS  = 32,
  localparam int unsigned AW       = $clog2(DEPTH),
  localparam int unsigned CW       = $clog2(DEPTH + 1),
  localparam int unsigned EW       = PRIO_BITS + TAG_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spq_pkg::FUNC_W-1:0]   in_func_i,
  input  logic [PRIO_BITS-1:0]         in_prio_i,
  input  logic [TAG_BITS-1:0]          in_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PRIO_BITS-1:0]         out_prio_o,
  output logic [TAG_BITS-1:0]          out_tag_o,
  output logic [spq_pkg::STATUS_W-1:0] out_status_o,
  output logic [CW-1:0]                out_fill_o,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [EW-1:0]                mem_wdata_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  logic [EW-1:0]                mem_rdata_i
);
  import spq_pkg::*;

  localparam int unsigned SW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_PLACE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  state_e                state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         left_q, left_d;
  logic [FUNC_W-1:0]     func_q;
  logic [PRIO_BITS-1:0]  prio_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [PRIO_BITS-1:0]  res_prio_q, res_prio_d;
  logic [TAG_BITS-1:0]   res_tag_q, res_tag_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic                  out_valid_q;
  logic [PRIO_BITS-1:0]  out_prio_q;
  logic [TAG_BITS-1:0]   out_tag_q;
  logic [STATUS_W-1:0]   out_st_q;
  logic [CW-1:0]         out_fill_q;

  logic                  accept;
  logic                  out_free;
  logic                  load_out;
  logic [SW-1:0]         last_sum;
  logic [AW-1:0]         last_idx;
  logic [PRIO_BITS-1:0]  rd_prio;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == S_FINISH) && out_free;
  assign rd_prio    = mem_rdata_i[EW-1:TAG_BITS];

  // slot of the back entry: head + count - 1, wrapped
  always_comb begin
    last_sum = SW'(head_q) + SW'(cnt_q) - SW'(1);
    if (last_sum >= SW'(DEPTH)) begin
      last_sum = last_sum - SW'(DEPTH);
    end
    last_idx = last_sum[AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    left_d      = left_q;
    res_prio_d  = res_prio_q;
    res_tag_d   = res_tag_q;
    res_st_d    = res_st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = {prio_q, tag_q};
    mem_raddr_o = pos_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_prio_d = '0;
          res_tag_d  = '0;
          res_st_d   = ST_OK;
          state_d    = S_FINISH;
          case (in_func_i)
            FUNC_PUSH: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_st_d = ST_FULL;
              end else if (cnt_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = head_q;
                mem_wdata_o = {in_prio_i, in_tag_i};
                cnt_d       = cnt_q + CW'(1);
              end else begin
                mem_raddr_o = last_idx;
                pos_d       = last_idx;
                left_d      = cnt_q;
                state_d     = S_SCAN;
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (cnt_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                mem_raddr_o = head_q;
                state_d     = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_prio_d = rd_prio;
        res_tag_d  = mem_rdata_i[TAG_BITS-1:0];
        if (func_q == FUNC_POP) begin
          head_d = idx_inc(head_q);
          cnt_d  = cnt_q - CW'(1);
        end
        state_d = S_FINISH;
      end
      S_SCAN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_inc(pos_q);
        if (rd_prio > prio_q) begin
          // move entry one slot back; next read is two slots off the write
          mem_wdata_o = mem_rdata_i;
          if (left_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            pos_d       = idx_dec(pos_q);
            mem_raddr_o = idx_dec(pos_q);
            left_d      = left_q - CW'(1);
          end
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_FINISH;
        end
      end
      S_PLACE: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + CW'(1);
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    left_q     <= left_d;
    res_prio_q <= res_prio_d;
    res_tag_q  <= res_tag_d;
    res_st_q   <= res_st_d;
    if (accept) begin
      func_q <= in_func_i;
      prio_q <= in_prio_i;
      tag_q  <= in_tag_i;
    end
    if (load_out) begin
      out_prio_q <= res_prio_q;
      out_tag_q  <= res_tag_q;
      out_st_q   <= res_st_q;
      out_fill_q <= cnt_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_prio_o   = out_prio_q;
  assign out_tag_o    = out_tag_q;
  assign out_status_o = out_st_q;
  assign out_fill_o   = out_fill_q;

endmodule

@@ rtl/core/stable_priority_queue_unit.sv @@
// Top level of the sorted priority queue: stream ports, sequencer and entry store.
//
// Channel  Dir  tdata (low bit up)                tuser
// s_axis   in   priority_req, tag                 func (0 push, 1 pop, 2 peek)
// m_axis   out  out_priority, out_tag, fill_level status (0 ok, 1 empty, 2 full)
//
// Sequencing: one word at a time. Refused ops, no-ops and a push into an empty
//   queue go straight to finish, pop and peek via a read state. A push steps
//   back from the tail, one step per held entry with a larger priority number,
//   then writes the new one (a memory read and a write per step, set by the
//   single read and write port of the store). Input reopens as results go out.
// Reset: rst_ni low empties the queue; the store itself is not cleared.
// Stalls: a finished word waits in the output register; the sequencer holds
//   in its last state while that register is full and not drained.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  localparam int unsigned CW       = $clog2(DEPTH + 1),
  localparam int unsigned IN_DW    = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW   = ((PRIO_BITS + TAG_BITS + CW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // priority_req, tag
  input  logic [IN_DW-1:0]             s_axis_tdata_i,
  // func
  input  logic [spq_pkg::FUNC_W-1:0]   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_priority, out_tag, fill_level, zero padding
  output logic [OUT_DW-1:0]            m_axis_tdata_o,
  // status
  output logic [spq_pkg::STATUS_W-1:0] m_axis_tuser_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = PRIO_BITS + TAG_BITS;

  logic [PRIO_BITS-1:0] out_prio;
  logic [TAG_BITS-1:0]  out_tag;
  logic [CW-1:0]        out_fill;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_rdata;

  // Entries sit in a circular window of the store, front at head, kept in
  // order of priority number then arrival. A push walks back from the tail,
  // shifting larger numbers one slot on, then drops the new entry in.
  spq_ctrl #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_func_i    (s_axis_tuser_i),
    .in_prio_i    (s_axis_tdata_i[PRIO_BITS-1:0]),
    .in_tag_i     (s_axis_tdata_i[EW-1:PRIO_BITS]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_prio_o   (out_prio),
    .out_tag_o    (out_tag),
    .out_status_o (m_axis_tuser_o),
    .out_fill_o   (out_fill),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // priority in the upper bits of an entry, tag below
  spq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = OUT_DW'({out_fill, out_tag, out_prio});

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checker for the priority queue, bound to the top level.
`include "stable_priority_queue_unit_macros.svh"

module spq_checker #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF,
  localparam int unsigned CW       = $clog2(DEPTH + 1),
  localparam int unsigned OUT_DW   = ((PRIO_BITS + TAG_BITS + CW + 7) / 8) * 8
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid_i,
  input logic                         s_tready_i,
  input logic                         m_tvalid_i,
  input logic                         m_tready_i,
  input logic [OUT_DW-1:0]            m_tdata_i,
  input logic [spq_pkg::STATUS_W-1:0] m_tuser_i
);
  import spq_pkg::*;

  localparam int unsigned EW = PRIO_BITS + TAG_BITS;

  logic [CW-1:0] fill;
  logic [EW-1:0] entry;

  assign fill  = m_tdata_i[EW+CW-1:EW];
  assign entry = m_tdata_i[EW-1:0];

  `SPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
  `SPQ_ASSERT_NEXT(a_one_word_in_flight, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i)
  `SPQ_ASSERT_IMPL(a_empty_report, clk_i, rst_ni, m_tvalid_i && m_tuser_i == ST_EMPTY, fill == '0 && entry == '0)
  `SPQ_ASSERT_IMPL(a_full_report, clk_i, rst_ni, m_tvalid_i && m_tuser_i == ST_FULL, fill == CW'(DEPTH) && entry == '0)

endmodule

bind stable_priority_queue_unit spq_checker #(
  .DEPTH     (DEPTH),
  .PRIO_BITS (PRIO_BITS),
  .TAG_BITS  (TAG_BITS)
) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

@@ bench/tb_stable_priority_queue_unit.sv @@
// Self-checking bench for the sorted priority queue: directed, back-pressure and random words.
module tb_stable_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned DEPTH  = DEPTH_DEF;
  localparam int unsigned PRIO_W = PRIO_BITS_DEF;
  localparam int unsigned TAG_W  = TAG_BITS_DEF;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned IN_W   = ((PRIO_W + TAG_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((PRIO_W + TAG_W + FILL_W + 7) / 8) * 8;
  localparam int unsigned PAD_W  = OUT_W - PRIO_W - TAG_W - FILL_W;

  // func code 3 has no enum member: the block treats it as a no-op
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  // Cycles with no word moving on either side before the run is abandoned.
  // The limit covers the longest push, the sender gaps, the receiver stalls and
  // the deliberate receiver hold, with room to spare.
  localparam int unsigned STALL_LIMIT = 2000;
  // Longest push plus margin, used for the quiet period at the end.
  localparam int unsigned DRAIN_WAIT  = 4 + DEPTH + 10;
  localparam int unsigned RAND_WORDS  = 900;
  localparam int unsigned RX_HOLD     = 300;

  typedef struct {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } queue_reply_t;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_W-1:0]     in_data  = '0;
  logic [FUNC_W-1:0]   in_func  = FUNC_PUSH;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_W-1:0]    out_data;
  logic [STATUS_W-1:0] out_status;

  stable_priority_queue_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),    // priority_req, tag
    .s_axis_tuser_i  (in_func),    // func
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),   // out_priority, out_tag, fill_level, padding
    .m_axis_tuser_o  (out_status)  // status
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow queue: sorted copy of what the block should hold, front at slot 0.
  // ---------------------------------------------------------------------------
  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  logic [TAG_W-1:0]  shadow_tag  [DEPTH];
  int unsigned       shadow_count = 0;

  queue_reply_t      pending_replies [$];
  int unsigned       mismatches = 0;

  // Knobs shared between the stimulus and the receiver.
  bit                tx_calm = 1'b0;  // sender offers back to back
  bit                rx_calm = 1'b0;  // receiver starts no random stalls
  int unsigned       rx_hold_req = 0; // long receiver hold requested by a test

  // Applies one operation to the shadow queue and returns the reply it owes.
  function automatic queue_reply_t queue_apply(logic [FUNC_W-1:0] op,
                                               logic [PRIO_W-1:0] pr,
                                               logic [TAG_W-1:0] tg);
    queue_reply_t r;
    int unsigned  pos;
    r.prio   = '0;
    r.tag    = '0;
    r.status = ST_OK;
    case (op)
      FUNC_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every held entry of equal or smaller number
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] <= pr) pos++;
          for (int unsigned k = shadow_count; k > pos; k--) begin
            shadow_prio[k] = shadow_prio[k-1];
            shadow_tag[k]  = shadow_tag[k-1];
          end
          shadow_prio[pos] = pr;
          shadow_tag[pos]  = tg;
          shadow_count++;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.prio = shadow_prio[0];
          r.tag  = shadow_tag[0];
          if (op == FUNC_POP) begin
            for (int unsigned k = 0; k + 1 < shadow_count; k++) begin
              shadow_prio[k] = shadow_prio[k+1];
              shadow_tag[k]  = shadow_tag[k+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.fill = shadow_count[FILL_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Ties, extremes and the full range of priority numbers.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return PRIO_W'($urandom_range(0, 3));
    if (r < 40) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (r < 50) return '1 - PRIO_W'($urandom_range(0, 3));
    return PRIO_W'($urandom);
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return TAG_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one word, waits for the handshake, records the reply owed.
  // Leaves tvalid high when no gap follows so that the next call can reuse it.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [FUNC_W-1:0] op, logic [PRIO_W-1:0] pr,
                           logic [TAG_W-1:0] tg);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_func  <= op;
    in_data  <= IN_W'({tg, pr});
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(queue_apply(op, pr, tg));
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops tvalid at the next falling edge, so no word is offered twice.
  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and long holds on request.
  // The hold is counted here, not in the stimulus.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : rx_drive
    int unsigned stall_left;
    int unsigned hold_left;
    if (rx_hold_req != 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  task automatic flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every word on the output is compared with the oldest
  // reply still owed, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_replies
    queue_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("unexpected word", '0, 64'(out_data));
      end else begin
        want = pending_replies.pop_front();
        if (out_data[PRIO_W-1:0] !== want.prio)
          flag_mismatch("out_priority", 64'(want.prio), 64'(out_data[PRIO_W-1:0]));
        if (out_data[PRIO_W +: TAG_W] !== want.tag)
          flag_mismatch("out_tag", 64'(want.tag), 64'(out_data[PRIO_W +: TAG_W]));
        if (out_data[PRIO_W+TAG_W +: FILL_W] !== want.fill)
          flag_mismatch("fill_level", 64'(want.fill),
                        64'(out_data[PRIO_W+TAG_W +: FILL_W]));
        if (out_data[OUT_W-1 -: PAD_W] !== '0)
          flag_mismatch("padding", '0, 64'(out_data[OUT_W-1 -: PAD_W]));
        if (out_status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(out_status));
      end
    end
  end

  // Watchdog: a run of cycles with no word moving on either side ends the run.
  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_stable_priority_queue_unit: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pop and peek on an empty queue report empty; code 3 does nothing.
  task automatic test_empty_queue();
    send_word(FUNC_POP,  '1, '1);
    send_word(FUNC_PEEK, '0, '0);
    send_word(FUNC_NOP,  '1, '1);
    quiet_input();
  endtask

  // Fill to the brim with extremes and ties, then one push too many is refused and the front is peeked.
  task automatic test_fill_and_refuse();
    logic [PRIO_W-1:0] prios [DEPTH] = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd128, 8'd255,
                                         8'd1, 8'd254, 8'd0, 8'd7, 8'd128, 8'd1,
                                         8'd255, 8'd64, 8'd0, 8'd200};
    for (int i = 0; i < DEPTH; i++)
      send_word(FUNC_PUSH, prios[i], (i % 2 == 0) ? 32'hFFFF_FFFF : TAG_W'(i));
    send_word(FUNC_PUSH, '0, '1);
    send_word(FUNC_PEEK, '0, '0);
    quiet_input();
  endtask

  // Equal numbers must leave in arrival order: the zeros come out first.
  task automatic test_front_removal();
    repeat (3) send_word(FUNC_POP, '0, '0);
    quiet_input();
  endtask

  // Receiver holds off while the sender keeps offering: the output register
  // fills and the block must stall its input without losing anything.
  task automatic test_back_pressure();
    tx_calm     = 1'b1;
    rx_hold_req = RX_HOLD;
    for (int i = 0; i < 24; i++)
      send_word(($urandom_range(0, 3) == 0) ? FUNC_POP : FUNC_PUSH, pick_prio(), pick_tag());
    tx_calm = 1'b0;
    quiet_input();
  endtask

  // Bursts that lean towards filling, draining or neither, so that the full
  // and empty boundaries are crossed again and again.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned lean;
    int unsigned burst;
    int unsigned r;
    logic [FUNC_W-1:0] op;
    sent = 0;
    while (sent < RAND_WORDS) begin
      lean    = $urandom_range(0, 2);
      burst   = $urandom_range(10, 50);
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        case (lean)
          0:       op = (r < 70) ? FUNC_PUSH : (r < 85) ? FUNC_POP : (r < 97) ? FUNC_PEEK : FUNC_NOP;
          1:       op = (r < 25) ? FUNC_PUSH : (r < 75) ? FUNC_POP : (r < 95) ? FUNC_PEEK : FUNC_NOP;
          default: op = (r < 45) ? FUNC_PUSH : (r < 80) ? FUNC_POP : (r < 95) ? FUNC_PEEK : FUNC_NOP;
        endcase
        send_word(op, pick_prio(), pick_tag());
        sent++;
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    quiet_input();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_fill_and_refuse();
    test_front_removal();
    test_back_pressure();
    test_random_traffic();

    // let every owed reply arrive, then a quiet spell for anything stray
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_stable_priority_queue_unit: clean");
    end else begin
      $display("tb_stable_priority_queue_unit: errors");
    end
    $finish;
  end

endmodule

@@ stable_priority_queue_unit.f @@
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_mem.sv
rtl/core/spq_ctrl.sv
rtl/core/stable_priority_queue_unit.sv
rtl/core/spq_checker.sv
bench/tb_stable_priority_queue_unit.sv
